// ===== rtl/core/kwct_pkg.sv =====
package kwct_pkg;

	// Table sizes
	localparam int KEY_DEPTH  = 1024;
	localparam int MOVE_DEPTH = 4096;
	localparam int RUN_MAX    = 256;

	// Derived widths
	localparam int KIDX_W = $clog2(KEY_DEPTH);
	localparam int KCNT_W = $clog2(KEY_DEPTH + 1);
	localparam int MIDX_W = $clog2(MOVE_DEPTH);
	localparam int MCNT_W = $clog2(MOVE_DEPTH + 1);
	localparam int LEN_W  = $clog2(RUN_MAX + 1);
	localparam int POS_W  = $clog2(MOVE_DEPTH + RUN_MAX + 1);

	// Field widths
	localparam int KEY_W  = 64;
	localparam int CODE_W = 15;
	localparam int WGT_W  = 16;
	localparam int RND_W  = 31;
	localparam int TOT_W  = 24;
	localparam int SQ_W   = 3;
	localparam int CNT5_W = $clog2(RND_W);

	localparam logic [TOT_W-1:0] WEIGHT_SAT = '1;

	// Request types
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_LOADED    = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    capture;
		logic    load_wr;
		logic    srch_rd;
		logic    srch_step;
		logic    run_rd;
		logic    mod_init;
		logic    mod_step;
		logic    walk_init;
		logic    walk_rd;
		logic    walk_step;
		logic    resp;
		status_t resp_status;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic req_lookup;
		logic load_full;
		logic srch_active;
		logic hit;
		logic run_zero;
		logic mod_last;
		logic walk_more;
		logic walk_pick;
	} dp_sts_t;

endpackage

// ===== rtl/core/kwct_datapath.sv =====
module kwct_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kwct_pkg::dp_cmd_t           cmd,
	output kwct_pkg::dp_sts_t           sts,
	input  logic                        req_type,
	input  logic [kwct_pkg::KEY_W-1:0]  key,
	input  logic [kwct_pkg::CODE_W-1:0] move_code,
	input  logic [kwct_pkg::WGT_W-1:0]  move_weight,
	input  logic [kwct_pkg::RND_W-1:0]  random_value,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [kwct_pkg::SQ_W-1:0]   src_file,
	output logic [kwct_pkg::SQ_W-1:0]   src_rank,
	output logic [kwct_pkg::SQ_W-1:0]   to_file,
	output logic [kwct_pkg::SQ_W-1:0]   to_rank,
	output logic [kwct_pkg::SQ_W-1:0]   promotion
);

	localparam int RUN_W  = kwct_pkg::MIDX_W + kwct_pkg::LEN_W + kwct_pkg::TOT_W;
	localparam int MOVE_W = kwct_pkg::WGT_W + kwct_pkg::CODE_W;

	// Memories
	logic [kwct_pkg::KEY_W-1:0] key_mem [kwct_pkg::KEY_DEPTH];
	logic [RUN_W-1:0]           run_mem [kwct_pkg::KEY_DEPTH];
	logic [MOVE_W-1:0]          move_mem [kwct_pkg::MOVE_DEPTH];

	// Request capture
	logic                        req_q;
	logic [kwct_pkg::KEY_W-1:0]  key_q;
	logic [kwct_pkg::CODE_W-1:0] code_q;
	logic [kwct_pkg::WGT_W-1:0]  wgt_q;
	logic [kwct_pkg::RND_W-1:0]  rnd_q;

	// Table bookkeeping
	logic [kwct_pkg::KCNT_W-1:0] key_cnt_q;
	logic [kwct_pkg::MCNT_W-1:0] move_cnt_q;
	logic [kwct_pkg::KEY_W-1:0]  last_key_q;
	logic [kwct_pkg::MIDX_W-1:0] last_start_q;
	logic [kwct_pkg::LEN_W-1:0]  last_len_q;
	logic [kwct_pkg::TOT_W-1:0]  last_tot_q;

	// Search / pick state
	logic [kwct_pkg::KCNT_W-1:0] lo_q, hi_q, mid_q;
	logic [kwct_pkg::KEY_W-1:0]  key_rd_q;
	logic [RUN_W-1:0]            run_rd_q;
	logic [MOVE_W-1:0]           move_rd_q;
	logic [kwct_pkg::TOT_W:0]    rem_q;
	logic [kwct_pkg::CNT5_W-1:0] bit_q;
	logic [kwct_pkg::LEN_W-1:0]  i_q;

	// Load decisions
	logic                        same_key;
	logic [kwct_pkg::TOT_W:0]    tot_sum;
	logic [kwct_pkg::TOT_W-1:0]  new_tot;
	logic [kwct_pkg::LEN_W-1:0]  new_len;
	logic [kwct_pkg::MIDX_W-1:0] new_start;
	logic [kwct_pkg::KIDX_W-1:0] run_wr_idx;
	logic [kwct_pkg::KCNT_W-1:0] mid;

	// Run record fields
	logic [kwct_pkg::MIDX_W-1:0] rd_start;
	logic [kwct_pkg::LEN_W-1:0]  rd_len;
	logic [kwct_pkg::TOT_W-1:0]  rd_tot;
	logic [kwct_pkg::POS_W-1:0]  pos;
	logic [kwct_pkg::TOT_W+1:0]  rem_shift;
	logic [kwct_pkg::WGT_W-1:0]  rd_wgt;

	assign same_key  = (key_cnt_q != '0) && (last_key_q == key_q);
	assign tot_sum   = {1'b0, last_tot_q} + (kwct_pkg::TOT_W + 1)'(wgt_q);
	assign new_tot   = same_key ? (tot_sum[kwct_pkg::TOT_W] ? kwct_pkg::WEIGHT_SAT
	                                                         : tot_sum[kwct_pkg::TOT_W-1:0])
	                            : kwct_pkg::TOT_W'(wgt_q);
	assign new_len   = same_key ? last_len_q + 1'b1 : kwct_pkg::LEN_W'(1);
	assign new_start = same_key ? last_start_q : move_cnt_q[kwct_pkg::MIDX_W-1:0];
	assign run_wr_idx = same_key ? kwct_pkg::KIDX_W'(key_cnt_q - 1'b1)
	                             : key_cnt_q[kwct_pkg::KIDX_W-1:0];
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);

	assign {rd_start, rd_len, rd_tot} = run_rd_q;
	assign pos       = kwct_pkg::POS_W'(rd_start) + kwct_pkg::POS_W'(i_q);
	assign rem_shift = {rem_q, rnd_q[bit_q]};
	assign rd_wgt    = move_rd_q[MOVE_W-1:kwct_pkg::CODE_W];

	// Status to controller
	always_comb begin
		sts.req_lookup  = (req_q == kwct_pkg::REQ_LOOKUP);
		sts.load_full   = (move_cnt_q == kwct_pkg::MCNT_W'(kwct_pkg::MOVE_DEPTH))
		                || (same_key && last_len_q == kwct_pkg::LEN_W'(kwct_pkg::RUN_MAX))
		                || (!same_key && key_cnt_q == kwct_pkg::KCNT_W'(kwct_pkg::KEY_DEPTH));
		sts.srch_active = (lo_q < hi_q);
		sts.hit         = (key_rd_q == key_q);
		sts.run_zero    = (rd_tot == '0);
		sts.mod_last    = (bit_q == '0);
		sts.walk_more   = (i_q < rd_len) && (pos < kwct_pkg::POS_W'(move_cnt_q));
		sts.walk_pick   = (rem_q < (kwct_pkg::TOT_W + 1)'(rd_wgt));
	end

	// Key memory
	always_ff @(posedge clk) begin
		if (cmd.load_wr && !same_key)
			key_mem[key_cnt_q[kwct_pkg::KIDX_W-1:0]] <= key_q;
		if (cmd.srch_rd)
			key_rd_q <= key_mem[mid[kwct_pkg::KIDX_W-1:0]];
	end

	// Run memory, read at the hit index
	always_ff @(posedge clk) begin
		if (cmd.load_wr)
			run_mem[run_wr_idx] <= {new_start, new_len, new_tot};
		if (cmd.run_rd)
			run_rd_q <= run_mem[mid_q[kwct_pkg::KIDX_W-1:0]];
	end

	// Move memory
	always_ff @(posedge clk) begin
		if (cmd.load_wr)
			move_mem[move_cnt_q[kwct_pkg::MIDX_W-1:0]] <= {wgt_q, code_q};
		if (cmd.walk_rd)
			move_rd_q <= move_mem[pos[kwct_pkg::MIDX_W-1:0]];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q  <= key;
			code_q <= move_code;
			wgt_q  <= move_weight;
			rnd_q  <= random_value;
		end
		if (cmd.load_wr) begin
			last_key_q   <= key_q;
			last_start_q <= new_start;
			last_len_q   <= new_len;
			last_tot_q   <= new_tot;
		end
		if (cmd.srch_rd)
			mid_q <= mid;
		// modulo by run total, one bit per cycle
		if (cmd.mod_init) begin
			rem_q <= '0;
			bit_q <= kwct_pkg::CNT5_W'(kwct_pkg::RND_W - 1);
		end else if (cmd.mod_step) begin
			if (rem_shift >= (kwct_pkg::TOT_W + 2)'(rd_tot))
				rem_q <= (kwct_pkg::TOT_W + 1)'(rem_shift - (kwct_pkg::TOT_W + 2)'(rd_tot));
			else
				rem_q <= rem_shift[kwct_pkg::TOT_W:0];
			bit_q <= bit_q - 1'b1;
		end else if (cmd.walk_step) begin
			rem_q <= rem_q - (kwct_pkg::TOT_W + 1)'(rd_wgt);
		end
		if (cmd.walk_init)
			i_q <= '0;
		else if (cmd.walk_step)
			i_q <= i_q + 1'b1;
	end

	// Control registers and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q      <= kwct_pkg::REQ_LOAD;
			key_cnt_q  <= '0;
			move_cnt_q <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			done       <= 1'b0;
			status     <= kwct_pkg::ST_LOADED;
			src_file   <= '0;
			src_rank   <= '0;
			to_file    <= '0;
			to_rank    <= '0;
			promotion  <= '0;
		end else begin
			done <= cmd.resp;
			if (cmd.capture) begin
				req_q <= req_type;
				lo_q  <= '0;
				hi_q  <= key_cnt_q;
			end
			if (cmd.load_wr) begin
				move_cnt_q <= move_cnt_q + 1'b1;
				if (!same_key)
					key_cnt_q <= key_cnt_q + 1'b1;
			end
			// narrow the half-open search interval
			if (cmd.srch_step) begin
				if (key_rd_q < key_q)
					lo_q <= mid_q + 1'b1;
				else
					hi_q <= mid_q;
			end
			if (cmd.srch_step == 1'b0 && cmd.run_rd)
				lo_q <= mid_q;
			if (cmd.resp) begin
				status <= cmd.resp_status;
				if (cmd.resp_status == kwct_pkg::ST_FOUND) begin
					to_file   <= move_rd_q[2:0];
					to_rank   <= move_rd_q[5:3];
					src_file  <= move_rd_q[8:6];
					src_rank  <= move_rd_q[11:9];
					promotion <= move_rd_q[14:12];
				end else begin
					to_file   <= '0;
					to_rank   <= '0;
					src_file  <= '0;
					src_rank  <= '0;
					promotion <= '0;
				end
			end
		end
	end

endmodule

// ===== rtl/core/kwct_ctrl.sv =====
module kwct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output kwct_pkg::dp_cmd_t cmd,
	input  kwct_pkg::dp_sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_LOAD,
		S_SRCH_CHK,
		S_SRCH_CMP,
		S_RUN_RD,
		S_RUN_CHK,
		S_MOD,
		S_WALK_CHK,
		S_WALK_CMP
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		cmd         = '0;
		cmd.resp_status = kwct_pkg::ST_LOADED;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = sts.req_lookup ? S_SRCH_CHK : S_LOAD;
			end
			S_LOAD: begin
				cmd.resp = 1'b1;
				if (sts.load_full) begin
					cmd.resp_status = kwct_pkg::ST_FULL;
				end else begin
					cmd.load_wr     = 1'b1;
					cmd.resp_status = kwct_pkg::ST_LOADED;
				end
				state_d = S_IDLE;
			end
			S_SRCH_CHK: begin
				if (sts.srch_active) begin
					cmd.srch_rd = 1'b1;
					state_d     = S_SRCH_CMP;
				end else begin
					cmd.resp        = 1'b1;
					cmd.resp_status = kwct_pkg::ST_NOT_FOUND;
					state_d         = S_IDLE;
				end
			end
			S_SRCH_CMP: begin
				if (sts.hit) begin
					state_d = S_RUN_RD;
					cmd.run_rd = 1'b0;
				end else begin
					cmd.srch_step = 1'b1;
					state_d       = S_SRCH_CHK;
				end
			end
			S_RUN_RD: begin
				// lo takes the hit index while the run record is read at that index
				cmd.run_rd = 1'b1;
				state_d    = S_RUN_CHK;
			end
			S_RUN_CHK: begin
				if (sts.run_zero) begin
					cmd.resp        = 1'b1;
					cmd.resp_status = kwct_pkg::ST_NOT_FOUND;
					state_d         = S_IDLE;
				end else begin
					cmd.mod_init = 1'b1;
					state_d      = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					cmd.walk_init = 1'b1;
					state_d       = S_WALK_CHK;
				end
			end
			S_WALK_CHK: begin
				if (sts.walk_more) begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WALK_CMP;
				end else begin
					cmd.resp        = 1'b1;
					cmd.resp_status = kwct_pkg::ST_NOT_FOUND;
					state_d         = S_IDLE;
				end
			end
			S_WALK_CMP: begin
				if (sts.walk_pick) begin
					cmd.resp        = 1'b1;
					cmd.resp_status = kwct_pkg::ST_FOUND;
					state_d         = S_IDLE;
				end else begin
					cmd.walk_step = 1'b1;
					state_d       = S_WALK_CHK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== rtl/core/keyed_weighted_choice_table.sv =====
// Weighted opening-move table. Pulse start while busy is low to transfer one
// request; exactly one result follows on the result ports with done high for a
// single cycle, and it must be taken then because the receiver cannot stall.
// A lookup runs a binary search of up to log2 of the key count plus one steps,
// each step one key-memory read; then a bit-serial modulo of the 31-bit random
// value by the run total; then a walk over the moves of the chosen run, one
// move-memory read each. No clearing pass is needed after reset.
module keyed_weighted_choice_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [kwct_pkg::KEY_W-1:0]  key,
	input  logic [kwct_pkg::CODE_W-1:0] move_code,
	input  logic [kwct_pkg::WGT_W-1:0]  move_weight,
	input  logic [kwct_pkg::RND_W-1:0]  random_value,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [kwct_pkg::SQ_W-1:0]   src_file,
	output logic [kwct_pkg::SQ_W-1:0]   src_rank,
	output logic [kwct_pkg::SQ_W-1:0]   to_file,
	output logic [kwct_pkg::SQ_W-1:0]   to_rank,
	output logic [kwct_pkg::SQ_W-1:0]   promotion
);

	kwct_pkg::dp_cmd_t cmd;
	kwct_pkg::dp_sts_t sts;

	// Sequencer
	kwct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	// Tables, search, modulo and walk
	kwct_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.key          (key),
		.move_code    (move_code),
		.move_weight  (move_weight),
		.random_value (random_value),
		.done         (done),
		.status       (status),
		.src_file     (src_file),
		.src_rank     (src_rank),
		.to_file      (to_file),
		.to_rank      (to_rank),
		.promotion    (promotion)
	);

endmodule
